>>> hw/rtl/dqts_pkg.sv
// ----------------------------------------------------------------------------
// Delta queue task scheduler package
// Shared widths, codes and the command record passed from front to back.
// ----------------------------------------------------------------------------
package dqts_pkg;

    localparam int SLOTS_DEF = 15;
    localparam int SLOT_W    = 4;
    localparam int CODE_W    = 8;
    localparam int WAIT_W    = 7;

    typedef enum logic [1:0] {
        KIND_ENQ  = 2'd0,
        KIND_TICK = 2'd1,
        KIND_DISP = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SS_IDLE    = 2'd0,
        SS_READY   = 2'd1,
        SS_DELAYED = 2'd2
    } slot_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SEARCH,
        BK_WALK,
        BK_TICK,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [CODE_W-1:0] task_code;
        logic [WAIT_W-1:0] wait_ticks;
    } cmd_t;

endpackage

>>> hw/rtl/dqts_front.sv
// ----------------------------------------------------------------------------
// Delta queue task scheduler front end
// Accepts commands and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module dqts_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           kind,
    input  logic [dqts_pkg::CODE_W-1:0] task_code,
    input  logic [dqts_pkg::WAIT_W-1:0] wait_ticks,
    output logic                 cmd_valid,
    output dqts_pkg::cmd_t       cmd,
    input  logic                 cmd_take
);
    import dqts_pkg::*;

    cmd_t       buf_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;
    cmd_t       in_cmd;

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = buf_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        in_cmd.kind       = kind;
        in_cmd.task_code  = task_code;
        in_cmd.wait_ticks = wait_ticks;
        wr_next  = do_push ? ~wr_reg : wr_reg;
        rd_next  = do_pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            buf_reg[wr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> hw/rtl/dqts_back.sv
// ----------------------------------------------------------------------------
// Delta queue task scheduler back end
// Runs commands on the slot table, one step per cycle unless held in emit.
// ----------------------------------------------------------------------------
module dqts_back #(
    parameter int SLOTS = dqts_pkg::SLOTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  dqts_pkg::cmd_t       cmd,
    output logic                 cmd_take,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           status,
    output logic [dqts_pkg::CODE_W-1:0] run_code,
    output logic [dqts_pkg::SLOT_W-1:0] slot_used,
    output logic [dqts_pkg::SLOT_W-1:0] released
);
    import dqts_pkg::*;

    typedef logic [SLOT_W-1:0] slot_t;

    back_state_t       st_reg, st_next;
    slot_state_t       sstat_reg [SLOTS+1];
    slot_state_t       sstat_next [SLOTS+1];
    logic [CODE_W-1:0] code_reg [SLOTS+1];
    logic [CODE_W-1:0] code_next [SLOTS+1];
    logic [WAIT_W-1:0] delta_reg [SLOTS+1];
    logic [WAIT_W-1:0] delta_next [SLOTS+1];
    slot_t             link_reg [SLOTS+1];
    slot_t             link_next [SLOTS+1];
    slot_t rh_reg, rh_next, rt_reg, rt_next, wh_reg, wh_next;
    slot_t cur_reg, cur_next, prev_reg, prev_next, new_reg, new_next;
    logic [WAIT_W-1:0] rem_reg, rem_next;
    cmd_t              c_reg, c_next;
    logic [1:0]        o_stat_reg, o_stat_next;
    logic [CODE_W-1:0] o_run_reg, o_run_next;
    slot_t             o_slot_reg, o_slot_next, o_rel_reg, o_rel_next;
    logic [1:0]        res_stat_reg, res_stat_next;
    logic [CODE_W-1:0] res_run_reg, res_run_next;
    slot_t             res_slot_reg, res_slot_next, res_rel_reg, res_rel_next;
    logic              o_full_reg, o_full_next;
    slot_t             nx;

    function automatic slot_t vs(input slot_t s);
        return (s >= slot_t'(1) && s <= slot_t'(SLOTS)) ? s : '0;
    endfunction

    assign empty     = !o_full_reg;
    assign status    = res_stat_reg;
    assign run_code  = res_run_reg;
    assign slot_used = res_slot_reg;
    assign released  = res_rel_reg;

    always_comb
    begin
        st_next       = st_reg;
        sstat_next    = sstat_reg;
        code_next     = code_reg;
        delta_next    = delta_reg;
        link_next     = link_reg;
        rh_next       = rh_reg;
        rt_next       = rt_reg;
        wh_next       = wh_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        new_next      = new_reg;
        rem_next      = rem_reg;
        c_next        = c_reg;
        o_stat_next   = o_stat_reg;
        o_run_next    = o_run_reg;
        o_slot_next   = o_slot_reg;
        o_rel_next    = o_rel_reg;
        res_stat_next = res_stat_reg;
        res_run_next  = res_run_reg;
        res_slot_next = res_slot_reg;
        res_rel_next  = res_rel_reg;
        o_full_next   = o_full_reg;
        cmd_take      = 1'b0;
        nx            = '0;
        if (pop && o_full_reg)
        begin
            o_full_next = 1'b0;
        end
        case (st_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take    = 1'b1;
                    c_next      = cmd;
                    o_stat_next = STAT_DONE;
                    o_run_next  = '0;
                    o_slot_next = '0;
                    o_rel_next  = '0;
                    cur_next    = slot_t'(1);
                    case (kind_t'(cmd.kind))
                        KIND_ENQ:  st_next = BK_SEARCH;
                        KIND_TICK:
                        begin
                            cur_next = vs(wh_reg);
                            if (vs(wh_reg) != '0 && delta_reg[vs(wh_reg)] != '0)
                            begin
                                delta_next[vs(wh_reg)] = delta_reg[vs(wh_reg)] - 1'b1;
                            end
                            st_next = BK_TICK;
                        end
                        KIND_DISP:
                        begin
                            if (vs(rh_reg) == '0)
                            begin
                                o_stat_next = STAT_EMPTY;
                            end
                            else
                            begin
                                o_run_next = code_reg[rh_reg];
                                o_slot_next = rh_reg;
                                sstat_next[rh_reg] = SS_IDLE;
                                rh_next = vs(link_reg[rh_reg]);
                                if (vs(link_reg[rh_reg]) == '0)
                                begin
                                    rt_next = '0;
                                end
                            end
                            st_next = BK_EMIT;
                        end
                        default: st_next = BK_EMIT;
                    endcase
                end
            end
            BK_SEARCH:
            begin
                // Scan one slot per cycle for the lowest idle entry.
                if (sstat_reg[cur_reg] == SS_IDLE)
                begin
                    code_next[cur_reg] = c_reg.task_code;
                    o_slot_next = cur_reg;
                    if (c_reg.wait_ticks == '0)
                    begin
                        sstat_next[cur_reg] = SS_READY;
                        link_next[cur_reg]  = '0;
                        if (vs(rh_reg) != '0 && vs(rt_reg) != '0)
                        begin
                            link_next[rt_reg] = cur_reg;
                        end
                        else
                        begin
                            rh_next = cur_reg;
                        end
                        rt_next = cur_reg;
                        st_next = BK_EMIT;
                    end
                    else
                    begin
                        new_next  = cur_reg;
                        prev_next = '0;
                        cur_next  = vs(wh_reg);
                        rem_next  = c_reg.wait_ticks;
                        st_next   = BK_WALK;
                    end
                end
                else if (cur_reg == slot_t'(SLOTS))
                begin
                    o_stat_next = STAT_FULL;
                    st_next     = BK_EMIT;
                end
                else
                begin
                    cur_next = cur_reg + 1'b1;
                end
            end
            BK_WALK:
            begin
                // Step along the delay list while entries are due no later.
                if (cur_reg != '0 && delta_reg[cur_reg] <= rem_reg)
                begin
                    rem_next  = rem_reg - delta_reg[cur_reg];
                    prev_next = cur_reg;
                    cur_next  = vs(link_reg[cur_reg]);
                end
                else
                begin
                    sstat_next[new_reg] = SS_DELAYED;
                    delta_next[new_reg] = rem_reg;
                    link_next[new_reg]  = cur_reg;
                    if (prev_reg != '0)
                    begin
                        link_next[prev_reg] = new_reg;
                    end
                    else
                    begin
                        wh_next = new_reg;
                    end
                    if (cur_reg != '0)
                    begin
                        delta_next[cur_reg] = delta_reg[cur_reg] - rem_reg;
                    end
                    st_next = BK_EMIT;
                end
            end
            BK_TICK:
            begin
                // Release one due head per cycle onto the ready tail.
                if (cur_reg != '0 && delta_reg[cur_reg] == '0)
                begin
                    nx = vs(link_reg[cur_reg]);
                    wh_next = nx;
                    sstat_next[cur_reg] = SS_READY;
                    link_next[cur_reg]  = '0;
                    if (vs(rh_reg) != '0 && vs(rt_reg) != '0)
                    begin
                        link_next[rt_reg] = cur_reg;
                    end
                    else
                    begin
                        rh_next = cur_reg;
                    end
                    rt_next    = cur_reg;
                    o_rel_next = o_rel_reg + 1'b1;
                    cur_next   = nx;
                end
                else
                begin
                    st_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                // The finished result moves to the output register once it is free.
                if (!o_full_reg || pop)
                begin
                    o_full_next   = 1'b1;
                    res_stat_next = o_stat_reg;
                    res_run_next  = o_run_reg;
                    res_slot_next = o_slot_reg;
                    res_rel_next  = o_rel_reg;
                    st_next       = BK_IDLE;
                end
            end
            default: st_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        code_reg  <= code_next;
        delta_reg <= delta_next;
        link_reg  <= link_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        new_reg   <= new_next;
        rem_reg   <= rem_next;
        c_reg     <= c_next;
        o_stat_reg <= o_stat_next;
        o_run_reg  <= o_run_next;
        o_slot_reg <= o_slot_next;
        o_rel_reg  <= o_rel_next;
        res_stat_reg <= res_stat_next;
        res_run_reg  <= res_run_next;
        res_slot_reg <= res_slot_next;
        res_rel_reg  <= res_rel_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= BK_IDLE;
            sstat_reg  <= '{default: SS_IDLE};
            rh_reg     <= '0;
            rt_reg     <= '0;
            wh_reg     <= '0;
            o_full_reg <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            sstat_reg  <= sstat_next;
            rh_reg     <= rh_next;
            rt_reg     <= rt_next;
            wh_reg     <= wh_next;
            o_full_reg <= o_full_next;
        end
    end

endmodule

>>> hw/rtl/delta_queue_task_scheduler.sv
// ----------------------------------------------------------------------------
// Delta queue task scheduler
// Slot table with a ready FIFO and a delta-sorted delay list.
// ----------------------------------------------------------------------------
// Commands enter through push/full: kind selects enqueue, tick or dispatch.
// A command is transferred when push is high and full is low. It lands in
// a two-entry command queue, so the front accepts while the back works.
// Each command gives one result, shown while empty is low and transferred
// when pop is high. The result register holds one result; while it waits
// the back end still executes the next command up to its final write.
// Dispatch and unknown kinds go from idle straight to emit; enqueue scans
// slots for an idle one and, if delayed, walks the delay list; tick frees
// due tasks one by one. The back end does one table step per cycle unless
// it waits in emit for pop, and takes a new command once the last is out.
// After reset all slots are idle, both lists are empty and no result is
// pending. If the receiver stalls, the command queue fills and full rises.
// ----------------------------------------------------------------------------
module delta_queue_task_scheduler #(
    parameter int SLOTS = dqts_pkg::SLOTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           kind,
    input  logic [dqts_pkg::CODE_W-1:0] task_code,
    input  logic [dqts_pkg::WAIT_W-1:0] wait_ticks,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           status,
    output logic [dqts_pkg::CODE_W-1:0] run_code,
    output logic [dqts_pkg::SLOT_W-1:0] slot_used,
    output logic [dqts_pkg::SLOT_W-1:0] released
);
    import dqts_pkg::*;

    logic cmd_valid, cmd_take;
    cmd_t cmd;

    dqts_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .kind(kind),
        .task_code(task_code), .wait_ticks(wait_ticks),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
    );

    dqts_back #(.SLOTS(SLOTS)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
        .cmd_take(cmd_take), .empty(empty), .pop(pop), .status(status),
        .run_code(run_code), .slot_used(slot_used), .released(released)
    );

endmodule

>>> verif/delta_queue_task_scheduler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Delta queue task scheduler testbench
// Drives enqueue, tick and dispatch commands through the push side. A
// scoreboard keeps its own copy of the slot table, ready queue and delay
// list, and checks every popped result field by field.
// ----------------------------------------------------------------------------
module delta_queue_task_scheduler_tb;
    import dqts_pkg::*;

    localparam int NSLOT = SLOTS_DEF;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]        status;
        logic [CODE_W-1:0] run_code;
        logic [SLOT_W-1:0] slot_used;
        logic [SLOT_W-1:0] released;
    } sched_result_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic [1:0] kind;
    logic [CODE_W-1:0] task_code;
    logic [WAIT_W-1:0] wait_ticks;
    logic empty;
    logic pop;
    logic [1:0] status;
    logic [CODE_W-1:0] run_code;
    logic [SLOT_W-1:0] slot_used;
    logic [SLOT_W-1:0] released;

    // Scoreboard copy of the scheduler state.
    slot_state_t        sb_state [1:NSLOT];
    logic [CODE_W-1:0]  sb_code  [1:NSLOT];
    logic [WAIT_W-1:0]  sb_delta [1:NSLOT];
    logic [SLOT_W-1:0]  sb_link  [1:NSLOT];
    logic [SLOT_W-1:0]  rdy_head, rdy_tail, dly_head, dly_tail;

    sched_result_t pending_results[$];
    int  error_count;
    int  sent_count;
    int  popped_count;
    int  release_total;
    int  full_seen;
    int  empty_seen;
    longint cycle_count;
    bit  pop_random;

    delta_queue_task_scheduler DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .kind       (kind),
        .task_code  (task_code),
        .wait_ticks (wait_ticks),
        .empty      (empty),
        .pop        (pop),
        .status     (status),
        .run_code   (run_code),
        .slot_used  (slot_used),
        .released   (released)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("cycle limit reached");
            $display("delta_queue_task_scheduler_tb NOT OK");
            $finish;
        end
    end

    function automatic logic [SLOT_W-1:0] slot_count_ok(input logic [SLOT_W-1:0] s);
        return (s >= 1 && s <= NSLOT) ? s : '0;
    endfunction

    function automatic void add_to_ready(input logic [SLOT_W-1:0] s);
        sb_state[s] = SS_READY;
        sb_link[s]  = '0;
        if (rdy_head != 0 && rdy_tail != 0)
            sb_link[rdy_tail] = s;
        else
            rdy_head = s;
        rdy_tail = s;
    endfunction

    function automatic void add_to_delay(input logic [SLOT_W-1:0] s,
                                         input logic [WAIT_W-1:0] w);
        logic [SLOT_W-1:0] prev;
        logic [SLOT_W-1:0] cur;
        logic [WAIT_W-1:0] rem;
        int steps;
        prev  = '0;
        cur   = dly_head;
        rem   = w;
        steps = 0;
        while (cur != 0 && sb_delta[cur] <= rem && steps < NSLOT)
        begin
            rem  = rem - sb_delta[cur];
            prev = cur;
            cur  = slot_count_ok(sb_link[cur]);
            steps++;
        end
        sb_state[s] = SS_DELAYED;
        sb_delta[s] = rem;
        sb_link[s]  = cur;
        if (prev != 0)
            sb_link[prev] = s;
        else
            dly_head = s;
        if (cur != 0)
            sb_delta[cur] = sb_delta[cur] - rem;
        else
            dly_tail = s;
    endfunction

    // Updates the scoreboard state and returns the result the command causes.
    function automatic sched_result_t schedule_step(input logic [1:0] k,
                                                    input logic [CODE_W-1:0] c,
                                                    input logic [WAIT_W-1:0] w);
        sched_result_t r;
        logic [SLOT_W-1:0] s;
        logic [SLOT_W-1:0] nx;
        int steps;
        r = '0;
        s = '0;
        if (k == KIND_ENQ)
        begin
            for (int i = 1; i <= NSLOT; i++)
            begin
                if (s == 0 && sb_state[i] == SS_IDLE)
                    s = SLOT_W'(i);
            end
            if (s == 0)
                r.status = STAT_FULL;
            else
            begin
                sb_code[s] = c;
                if (w == 0)
                    add_to_ready(s);
                else
                    add_to_delay(s, w);
                r.slot_used = s;
            end
        end
        else if (k == KIND_TICK)
        begin
            s = dly_head;
            steps = 0;
            if (s != 0 && sb_delta[s] > 0)
                sb_delta[s] = sb_delta[s] - 1'b1;
            while (s != 0 && sb_delta[s] == 0 && steps < NSLOT)
            begin
                nx = slot_count_ok(sb_link[s]);
                dly_head = nx;
                if (nx == 0)
                    dly_tail = '0;
                add_to_ready(s);
                r.released = r.released + 1'b1;
                s = nx;
                steps++;
            end
        end
        else if (k == KIND_DISP)
        begin
            s = rdy_head;
            if (s == 0)
                r.status = STAT_EMPTY;
            else
            begin
                r.run_code  = sb_code[s];
                r.slot_used = s;
                sb_state[s] = SS_IDLE;
                rdy_head = slot_count_ok(sb_link[s]);
                if (rdy_head == 0)
                    rdy_tail = '0;
            end
        end
        return r;
    endfunction

    // Sends one command after a random gap; holds push across back-to-back sends.
    task automatic send_command(input kind_t k, input logic [CODE_W-1:0] c,
                                input logic [WAIT_W-1:0] w, input bit no_gap = 0);
        int gap;
        sched_result_t r;
        gap = no_gap ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11));
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push       <= 1'b1;
        kind       <= k;
        task_code  <= c;
        wait_ticks <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        r = schedule_step(k, c, w);
        if (r.status == STAT_FULL)
            full_seen++;
        if (r.status == STAT_EMPTY)
            empty_seen++;
        release_total += r.released;
        pending_results.push_back(r);
        sent_count++;
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Result side: random stalls between transfers, with stall-free stretches.
    initial
    begin
        int stall;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = pop_random ? $urandom_range(0, 11) : 0;
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        sched_result_t exp_r;
        if (rst_n && pop && !empty)
        begin
            popped_count++;
            if (pending_results.size() == 0)
            begin
                $error("result popped with nothing expected");
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.status)
                begin
                    $error("status: expected %0d, got %0d", exp_r.status, status);
                    error_count++;
                end
                if (run_code !== exp_r.run_code)
                begin
                    $error("run_code: expected %0d, got %0d", exp_r.run_code, run_code);
                    error_count++;
                end
                if (slot_used !== exp_r.slot_used)
                begin
                    $error("slot_used: expected %0d, got %0d", exp_r.slot_used, slot_used);
                    error_count++;
                end
                if (released !== exp_r.released)
                begin
                    $error("released: expected %0d, got %0d", exp_r.released, released);
                    error_count++;
                end
            end
        end
    end

    task automatic test_directed_edges();
        send_command(KIND_DISP, 8'h00, 7'd0);
        send_command(KIND_TICK, 8'h00, 7'd0);
        send_command(KIND_NONE, 8'hFF, 7'h7F);
        send_command(KIND_ENQ, 8'hFF, 7'd0);
        send_command(KIND_ENQ, 8'h00, 7'h7F);
        send_command(KIND_ENQ, 8'hA5, 7'd3);
        // Equal due time keeps FIFO order and gets a zero delta.
        send_command(KIND_ENQ, 8'h5A, 7'd3);
        send_command(KIND_ENQ, 8'h3C, 7'd1);
        send_command(KIND_DISP, 8'h00, 7'd0);
        repeat (3) send_command(KIND_TICK, 8'h00, 7'd0, 1);
        repeat (4) send_command(KIND_DISP, 8'h00, 7'd0, 1);
    endtask

    task automatic test_table_full();
        // Fill every slot, overflow once, then empty the table again.
        for (int i = 0; i < NSLOT + 1; i++)
            send_command(KIND_ENQ, 8'(i + 8'h40), 7'($urandom_range(0, 2)), 1);
        for (int i = 0; i < 130; i++)
            send_command(KIND_TICK, 8'h00, 7'd0, 1);
        for (int i = 0; i < NSLOT + 1; i++)
            send_command(KIND_DISP, 8'h00, 7'd0, 1);
        drain_results();
    endtask

    task automatic test_random_mix(input int count);
        int sel;
        logic [WAIT_W-1:0] w;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 40)
            begin
                case ($urandom_range(0, 3))
                    0: w = '0;
                    1: w = 7'($urandom_range(1, 4));
                    2: w = 7'($urandom_range(0, 12));
                    default: w = 7'($urandom);
                endcase
                send_command(KIND_ENQ, 8'($urandom), w);
            end
            else if (sel < 72)
                send_command(KIND_TICK, 8'($urandom), 7'($urandom));
            else if (sel < 97)
                send_command(KIND_DISP, 8'($urandom), 7'($urandom));
            else
                send_command(KIND_NONE, 8'($urandom), 7'($urandom));
            if (i == count / 2)
            begin
                // The sender holds off until every expected transfer is back.
                drain_results();
                pop_random = 1'b0;
            end
        end
    endtask

    initial
    begin
        error_count   = 0;
        sent_count    = 0;
        popped_count  = 0;
        release_total = 0;
        full_seen     = 0;
        empty_seen    = 0;
        cycle_count   = 0;
        pop_random    = 1'b1;
        push          = 1'b0;
        kind          = KIND_NONE;
        task_code     = '0;
        wait_ticks    = '0;
        rdy_head = '0;
        rdy_tail = '0;
        dly_head = '0;
        dly_tail = '0;
        for (int i = 1; i <= NSLOT; i++)
        begin
            sb_state[i] = SS_IDLE;
            sb_code[i]  = '0;
            sb_delta[i] = '0;
            sb_link[i]  = '0;
        end
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_table_full();
        test_random_mix(210);
        pop_random = 1'b1;
        test_random_mix(210);
        drain_results();
        repeat (50) @(posedge clk);

        $display("%0d commands sent, %0d results checked, %0d tasks released by ticks",
                 sent_count, popped_count, release_total);
        $display("%0d full-table enqueues and %0d empty-queue dispatches seen",
                 full_seen, empty_seen);
        if (error_count == 0 && pending_results.size() == 0)
            $display("delta_queue_task_scheduler_tb OK");
        else
            $display("delta_queue_task_scheduler_tb NOT OK");
        $finish;
    end

endmodule
